[hdl/vwpa_pkg.sv]
// shared constants, command and status types for the waveform and parade accumulator
// used by every module of the block but the ram; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package vwpa_pkg;

  // trace geometry
  localparam int MAX_COLUMNS = 512;
  localparam int LEVELS      = 256;
  localparam int CHANNELS    = 3;
  localparam int TRACES      = CHANNELS + 1;
  localparam int DEPTH       = MAX_COLUMNS * LEVELS;
  localparam int ADDR_W      = $clog2(DEPTH);

  // field widths
  localparam int KIND_W  = 2;
  localparam int COL_W   = 9;
  localparam int COMP_W  = 8;
  localparam int SEL_W   = 2;
  localparam int LEVEL_W = 8;
  localparam int DATA_W  = 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ACCUM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // trace selection codes and ram lanes
  localparam logic [SEL_W-1:0] TRACE_LUMA  = 2'd0;
  localparam logic [SEL_W-1:0] TRACE_RED   = 2'd1;
  localparam logic [SEL_W-1:0] TRACE_GREEN = 2'd2;
  localparam logic [SEL_W-1:0] TRACE_BLUE  = 2'd3;

  // bt.601 luma weights and divide by 1000 via reciprocal 1048 / 2^20
  localparam int SUM_W       = 18;
  localparam int EST_W       = 9;
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 20;
  localparam logic [9:0]         W_RED   = 10'd299;
  localparam logic [9:0]         W_GREEN = 10'd587;
  localparam logic [9:0]         W_BLUE  = 10'd114;
  localparam logic [9:0]         DIVISOR = 10'd1000;
  localparam logic [RECIP_W-1:0] RECIP   = 11'd1048;

  localparam logic [DATA_W-1:0] STEP_RESET = 8'd40;
  localparam logic [DATA_W-1:0] SAT_MAX    = 8'hFF;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_EST   = 8'b0000_1000,
    S_FIX   = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_WR    = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic load_in;
    logic calc_sum;
    logic calc_est;
    logic calc_fix;
    logic mem_rd;
    logic mem_wr;
    logic clr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              clr_last;
    logic              out_free;
  } sts_t;

  // cell address is level * columns + column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LEVEL_W-1:0] level,
                                                  input logic [COL_W-1:0]   column);
    logic [ADDR_W:0] acc;
    acc = (ADDR_W+1)'(level) * (ADDR_W+1)'(MAX_COLUMNS) + (ADDR_W+1)'(column);
    return acc[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/vwpa_ram.sv]
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vwpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/vwpa_ctrl.sv]
// sequencing state machine for the accumulator
// depends on vwpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module vwpa_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [vwpa_pkg::KIND_W-1:0] in_kind_i,
  input  wire vwpa_pkg::sts_t              sts_i,
  output logic                             in_ready_o,
  output vwpa_pkg::cmd_t                   cmd_o
);

  vwpa_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      vwpa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (in_kind_i)
            vwpa_pkg::KIND_ACCUM: state_d = vwpa_pkg::S_SUM;
            vwpa_pkg::KIND_READ:  state_d = vwpa_pkg::S_RD;
            vwpa_pkg::KIND_CLEAR: state_d = vwpa_pkg::S_CLEAR;
            default:              state_d = vwpa_pkg::S_IDLE;
          endcase
        end
      end
      vwpa_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = vwpa_pkg::S_IDLE;
        end
      end
      vwpa_pkg::S_SUM: begin
        cmd_o.calc_sum = 1'b1;
        state_d        = vwpa_pkg::S_EST;
      end
      vwpa_pkg::S_EST: begin
        cmd_o.calc_est = 1'b1;
        state_d        = vwpa_pkg::S_FIX;
      end
      vwpa_pkg::S_FIX: begin
        cmd_o.calc_fix = 1'b1;
        state_d        = vwpa_pkg::S_RD;
      end
      vwpa_pkg::S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = (sts_i.kind == vwpa_pkg::KIND_READ) ? vwpa_pkg::S_RESP : vwpa_pkg::S_WR;
      end
      vwpa_pkg::S_WR: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = vwpa_pkg::S_IDLE;
      end
      vwpa_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = vwpa_pkg::S_IDLE;
        end
      end
      default: state_d = vwpa_pkg::S_IDLE;
    endcase
  end

  // reset lands in the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwpa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/vwpa_datapath.sv]
// luma arithmetic, trace rams, clear counter, step and output registers
// depends on vwpa_pkg and vwpa_ram
`timescale 1ns / 1ps
`default_nettype none

module vwpa_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire vwpa_pkg::cmd_t               cmd_i,
  output vwpa_pkg::sts_t                    sts_o,
  input  wire logic [vwpa_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [vwpa_pkg::COL_W-1:0]   column_i,
  input  wire logic [vwpa_pkg::COMP_W-1:0]  red_i,
  input  wire logic [vwpa_pkg::COMP_W-1:0]  green_i,
  input  wire logic [vwpa_pkg::COMP_W-1:0]  blue_i,
  input  wire logic [vwpa_pkg::SEL_W-1:0]   trace_select_i,
  input  wire logic [vwpa_pkg::LEVEL_W-1:0] read_level_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [vwpa_pkg::DATA_W-1:0]  cfg_data_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic      [vwpa_pkg::DATA_W-1:0]  intensity_o
);

  localparam int TR = vwpa_pkg::TRACES;
  localparam int AW = vwpa_pkg::ADDR_W;
  localparam int DW = vwpa_pkg::DATA_W;

  // captured item
  logic [vwpa_pkg::KIND_W-1:0]  kind_q;
  logic [vwpa_pkg::COL_W-1:0]   col_q;
  logic [vwpa_pkg::COMP_W-1:0]  red_q, green_q, blue_q;
  logic [vwpa_pkg::SEL_W-1:0]   sel_q;
  logic [vwpa_pkg::LEVEL_W-1:0] lvl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q  <= kind_i;
      col_q   <= column_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      sel_q   <= trace_select_i;
      lvl_q   <= read_level_i;
    end
  end

  // luma: weighted sum, reciprocal estimate, one step correction
  logic [vwpa_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [vwpa_pkg::EST_W-1:0] est_q, est_d;
  logic [vwpa_pkg::LEVEL_W-1:0] luma_q, luma_d;
  logic [vwpa_pkg::SUM_W+vwpa_pkg::RECIP_W-1:0] prod_est;
  logic [vwpa_pkg::SUM_W:0] prod_back, rem;
  logic [vwpa_pkg::EST_W-1:0] quot;

  assign sum_d = vwpa_pkg::SUM_W'(red_q * vwpa_pkg::W_RED)
               + vwpa_pkg::SUM_W'(green_q * vwpa_pkg::W_GREEN)
               + vwpa_pkg::SUM_W'(blue_q * vwpa_pkg::W_BLUE);

  assign prod_est = (vwpa_pkg::SUM_W+vwpa_pkg::RECIP_W)'(sum_q) * vwpa_pkg::RECIP;
  assign est_d    = prod_est[vwpa_pkg::RECIP_SHIFT +: vwpa_pkg::EST_W];

  assign prod_back = (vwpa_pkg::SUM_W+1)'(est_q) * vwpa_pkg::DIVISOR;
  assign rem       = {1'b0, sum_q} - prod_back;

  always_comb begin
    quot = est_q;
    if (rem >= (vwpa_pkg::SUM_W+1)'(vwpa_pkg::DIVISOR)) begin
      quot = est_q + 1'b1;
    end
    // clamp kept for safety, weights stay below it
    luma_d = quot[vwpa_pkg::EST_W-1] ? vwpa_pkg::SAT_MAX : quot[vwpa_pkg::LEVEL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_sum) sum_q  <= sum_d;
    if (cmd_i.calc_est) est_q  <= est_d;
    if (cmd_i.calc_fix) luma_q <= luma_d;
  end

  // step register
  logic [DW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= vwpa_pkg::STEP_RESET;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  // clear sweep counter
  logic [AW-1:0] clr_cnt_q;
  logic          clr_last;

  assign clr_last = (clr_cnt_q == AW'(vwpa_pkg::DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
    end
  end

  // trace rams
  logic is_read, col_ok;
  logic [vwpa_pkg::LEVEL_W-1:0] lvl   [TR];
  logic [AW-1:0]                addr  [TR];
  logic [DW-1:0]                rdata [TR];
  logic [DW-1:0]                wdata [TR];
  logic                         we;

  assign is_read = (kind_q == vwpa_pkg::KIND_READ);
  assign col_ok  = (int'(col_q) < vwpa_pkg::MAX_COLUMNS);
  assign lvl[0]  = is_read ? lvl_q : luma_q;
  assign lvl[1]  = is_read ? lvl_q : red_q;
  assign lvl[2]  = is_read ? lvl_q : green_q;
  assign lvl[3]  = is_read ? lvl_q : blue_q;
  assign we      = cmd_i.clr_step | (cmd_i.mem_wr & col_ok);

  for (genvar t = 0; t < TR; t++) begin : g_trace
    logic [DW:0] bumped;

    assign bumped   = {1'b0, rdata[t]} + {1'b0, step_q};
    assign addr[t]  = cmd_i.clr_step ? clr_cnt_q : vwpa_pkg::cell_addr(lvl[t], col_q);
    assign wdata[t] = cmd_i.clr_step ? '0 : (bumped[DW] ? vwpa_pkg::SAT_MAX : bumped[DW-1:0]);

    vwpa_ram #(
      .WIDTH(DW),
      .DEPTH(vwpa_pkg::DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .re_i   (cmd_i.mem_rd),
      .we_i   (we),
      .addr_i (addr[t]),
      .wdata_i(wdata[t]),
      .rdata_o(rdata[t])
    );
  end

  // output register
  logic [DW-1:0] sel_data;
  logic [DW-1:0] out_q;
  logic          out_valid_q;

  always_comb begin
    case (sel_q)
      vwpa_pkg::TRACE_LUMA:  sel_data = rdata[0];
      vwpa_pkg::TRACE_RED:   sel_data = rdata[1];
      vwpa_pkg::TRACE_GREEN: sel_data = rdata[2];
      default:               sel_data = rdata[3];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= col_ok ? sel_data : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign intensity_o    = out_q;
  assign sts_o.kind     = kind_q;
  assign sts_o.clr_last = clr_last;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

[hdl/video_waveform_parade_accumulator.sv]
// accumulate: runs the accept, sum, estimate, correct, ram read and ram write states in order
// read: accept, ram read, then the result is registered once the output register is free
// clear: sweep over all MAX_COLUMNS*LEVELS addresses (131072) writing zero to all four trace rams
// throughput: one item at a time, each kind runs its whole sequence before the next is taken
// reset: asynchronous active low; afterwards the same clear sweep runs with
// in_ready_o low, configuration writes are still taken
`timescale 1ns / 1ps
`default_nettype none

module video_waveform_parade_accumulator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // item channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [vwpa_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [vwpa_pkg::COL_W-1:0]   column_i,
  input  wire logic [vwpa_pkg::COMP_W-1:0]  red_i,
  input  wire logic [vwpa_pkg::COMP_W-1:0]  green_i,
  input  wire logic [vwpa_pkg::COMP_W-1:0]  blue_i,
  input  wire logic [vwpa_pkg::SEL_W-1:0]   trace_select_i,
  input  wire logic [vwpa_pkg::LEVEL_W-1:0] read_level_i,
  // intensity step write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [vwpa_pkg::DATA_W-1:0]  cfg_data_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [vwpa_pkg::DATA_W-1:0]  intensity_o
);

  vwpa_pkg::cmd_t cmd;
  vwpa_pkg::sts_t sts;

  // the step register is always writable
  assign cfg_ready_o = 1'b1;

  // sequencer: decides per item kind which datapath steps run
  vwpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_kind_i (kind_i),
    .sts_i     (sts),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  // arithmetic, four trace rams and the output register
  vwpa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (kind_i),
    .column_i      (column_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .trace_select_i(trace_select_i),
    .read_level_i  (read_level_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .intensity_o   (intensity_o)
  );

endmodule

`default_nettype wire

[hdl/vwpa_checker.sv]
// port level assertions for the accumulator, bound to the top level
// depends on vwpa_pkg and video_waveform_parade_accumulator
`timescale 1ns / 1ps
`default_nettype none

module vwpa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [vwpa_pkg::KIND_W-1:0] kind_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [vwpa_pkg::DATA_W-1:0] intensity_o
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(intensity_o))
    else $error("result dropped or changed while stalled");

  // one item at a time; an ignored kind leaves the block ready
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == vwpa_pkg::KIND_ACCUM ||
      kind_i == vwpa_pkg::KIND_READ || kind_i == vwpa_pkg::KIND_CLEAR) |=> !in_ready_o)
    else $error("ready high right after a transaction");

  // accumulate never produces a result
  a_accum_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == vwpa_pkg::KIND_ACCUM |=> !$rose(out_valid_o))
    else $error("result raised by an accumulate");

  // clear sweep keeps the block busy
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == vwpa_pkg::KIND_CLEAR |=> !in_ready_o ##1 !in_ready_o)
    else $error("clear finished too early");

endmodule

bind video_waveform_parade_accumulator vwpa_checker u_checker (.*);

`default_nettype wire

[dv/video_waveform_parade_accumulator_test.sv]
// self-checking testbench for the waveform and parade accumulator: pixel, read, clear traffic
// keeps its own copy of every trace and checks each intensity; depends on vwpa_pkg and the rtl
`timescale 1ns / 1ps

module video_waveform_parade_accumulator_test;
  import vwpa_pkg::*;

  // kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0] STEP_AT_RESET = 8'd40;
  // an accumulate may still be in flight once the last result is in
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 20;
  // four clear sweeps plus stalled traffic, taken several times over
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COL_W-1:0]   column;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [SEL_W-1:0]   trace_select;
    logic [LEVEL_W-1:0] read_level;
  } scope_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [KIND_W-1:0]  kind_i = '0;
  logic [COL_W-1:0]   column_i = '0;
  logic [COMP_W-1:0]  red_i = '0;
  logic [COMP_W-1:0]  green_i = '0;
  logic [COMP_W-1:0]  blue_i = '0;
  logic [SEL_W-1:0]   trace_select_i = '0;
  logic [LEVEL_W-1:0] read_level_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [DATA_W-1:0]  cfg_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DATA_W-1:0]  intensity_o;

  // trace model: cells never hit since the last clear read as zero
  logic [DATA_W-1:0] trace_cells [int];
  logic [DATA_W-1:0] step_model = STEP_AT_RESET;
  logic [DATA_W-1:0] intensity_q [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  rx_idle_on = 1'b1;
  bit  tx_idle_on = 1'b1;

  video_waveform_parade_accumulator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .column_i       (column_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .trace_select_i (trace_select_i),
    .read_level_i   (read_level_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .intensity_o    (intensity_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // trace model
  // ---------------------------------------------------------------------------

  // bt.601 luma with truncating divide, clamped to the top level
  function automatic logic [LEVEL_W-1:0] luma_of(input logic [COMP_W-1:0] r,
                                                 input logic [COMP_W-1:0] g,
                                                 input logic [COMP_W-1:0] b);
    int weighted;
    weighted = (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
    if (weighted > 255) weighted = 255;
    return weighted[LEVEL_W-1:0];
  endfunction

  // one flat key space: trace, then level, then column
  function automatic int cell_key(input int trace, input int level, input int column);
    return (trace * LEVELS + level) * MAX_COLUMNS + column;
  endfunction

  // saturating add of the current step
  function automatic void bump_cell(input int key);
    int sum;
    sum = trace_cells.exists(key) ? int'(trace_cells[key]) : 0;
    sum = sum + int'(step_model);
    trace_cells[key] = (sum > 255) ? 8'hFF : sum[DATA_W-1:0];
  endfunction

  function automatic void predict_item(input scope_item_t item);
    logic [DATA_W-1:0] cell_value;
    int                key;
    case (item.kind)
      KIND_ACCUM: begin
        // columns past the trace width leave every cell alone
        if (int'(item.column) < MAX_COLUMNS) begin
          bump_cell(cell_key(TRACE_LUMA, luma_of(item.red, item.green, item.blue),
                             item.column));
          bump_cell(cell_key(TRACE_RED, item.red, item.column));
          bump_cell(cell_key(TRACE_GREEN, item.green, item.column));
          bump_cell(cell_key(TRACE_BLUE, item.blue, item.column));
        end
      end
      KIND_READ: begin
        cell_value = '0;
        key = cell_key(item.trace_select, item.read_level, item.column);
        if (int'(item.column) < MAX_COLUMNS && trace_cells.exists(key)) begin
          cell_value = trace_cells[key];
        end
        intensity_q.push_back(cell_value);
      end
      KIND_CLEAR: trace_cells.delete();
      default: begin
        // unused kind: no state change, no result
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitors: all handshakes sampled at the rising edge, pre-update values
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : transaction_check
    logic [DATA_W-1:0] want;
    if (rst_ni) begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid_o && out_ready_i) begin
        if (intensity_q.size() == 0) begin
          report_mismatch("intensity with nothing outstanding", intensity_o, 0);
        end else begin
          want = intensity_q.pop_front();
          if (intensity_o !== want) report_mismatch("intensity", intensity_o, want);
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_item({kind_i, column_i, red_i, green_i, blue_i, trace_select_i,
                      read_level_i});
      end
      if (cfg_valid_i && cfg_ready_o) step_model = cfg_data_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: long hold-off on request, else random stall bursts
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int burst_left;
    burst_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_ready_i <= 1'b0;
        burst_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        burst_left = $urandom_range(0, 14);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item sender and configuration writes
  // ---------------------------------------------------------------------------

  // returns at the edge that took the transaction, with valid still high
  task automatic send_item(input scope_item_t item);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 15)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    {kind_i, column_i, red_i, green_i, blue_i, trace_select_i, read_level_i} <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender pauses until every outstanding read has come back
  task automatic wait_results_drained(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (intensity_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [DATA_W-1:0] value);
    wait_results_drained(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // unused fields of each kind are filled at random
  function automatic scope_item_t pixel_item(input logic [COL_W-1:0] column,
                                             input logic [COMP_W-1:0] r,
                                             input logic [COMP_W-1:0] g,
                                             input logic [COMP_W-1:0] b);
    scope_item_t item;
    item = scope_item_t'({$urandom, $urandom});
    item.kind = KIND_ACCUM;
    item.column = column;
    item.red = r;
    item.green = g;
    item.blue = b;
    return item;
  endfunction

  function automatic scope_item_t read_item(input logic [COL_W-1:0] column,
                                            input logic [SEL_W-1:0] trace,
                                            input logic [LEVEL_W-1:0] level);
    scope_item_t item;
    item = scope_item_t'({$urandom, $urandom});
    item.kind = KIND_READ;
    item.column = column;
    item.trace_select = trace;
    item.read_level = level;
    return item;
  endfunction

  function automatic scope_item_t bare_item(input logic [KIND_W-1:0] kind);
    scope_item_t item;
    item = scope_item_t'({$urandom, $urandom});
    item.kind = kind;
    return item;
  endfunction

  // mostly random, with a fair share of black and full-scale components
  function automatic logic [COMP_W-1:0] pick_component();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return COMP_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // black pixel at column 0 with the step left at its reset value
  task automatic test_reset_step();
    send_item(pixel_item(9'd0, 8'd0, 8'd0, 8'd0));
    send_item(read_item(9'd0, TRACE_LUMA, 8'd0));
    send_item(read_item(9'd0, TRACE_RED, 8'd0));
    send_item(read_item(9'd0, TRACE_GREEN, 8'd0));
    send_item(read_item(9'd0, TRACE_BLUE, 8'd0));
    send_item(read_item(9'd0, TRACE_LUMA, 8'd1));
  endtask

  // last column, full-scale and pure red pixels, saturation, zero step, unused kind
  task automatic test_extremes();
    send_item(pixel_item(9'd511, 8'd255, 8'd255, 8'd255));
    send_item(read_item(9'd511, TRACE_LUMA, 8'd255));
    send_item(pixel_item(9'd300, 8'd255, 8'd0, 8'd0));
    send_item(read_item(9'd300, TRACE_LUMA, luma_of(8'd255, 8'd0, 8'd0)));
    write_step(8'd255);
    send_item(pixel_item(9'd511, 8'd255, 8'd255, 8'd255));
    send_item(pixel_item(9'd511, 8'd255, 8'd255, 8'd255));
    send_item(read_item(9'd511, TRACE_BLUE, 8'd255));
    send_item(bare_item(KIND_UNUSED));
    send_item(read_item(9'd300, TRACE_GREEN, 8'd0));
    write_step(8'd0);
    send_item(pixel_item(9'd300, 8'd255, 8'd0, 8'd0));
    send_item(read_item(9'd300, TRACE_RED, 8'd255));
  endtask

  // one sweep, then cells that were hit read back as zero
  task automatic test_clear();
    send_item(bare_item(KIND_CLEAR));
    send_item(read_item(9'd511, TRACE_LUMA, 8'd255));
    send_item(read_item(9'd0, TRACE_GREEN, 8'd0));
  endtask

  // sink holds off while reads keep coming, so the block stalls its input
  task automatic test_backpressure();
    int n;
    write_step(8'd9);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left = 300;
    for (n = 0; n < 30; n++) begin
      if (n % 3 == 0) send_item(pixel_item(9'd5, 8'd10, 8'd20, 8'd30));
      else send_item(read_item(9'd5, TRACE_BLUE, 8'd30));
    end
    wait_results_drained(0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // pixels on a few hot columns, reads mostly aimed at cells just hit
  task automatic test_random_traffic();
    logic [DATA_W-1:0]  steps [6];
    logic [COL_W-1:0]   column_pool [8];
    scope_item_t        recent_q [$];
    scope_item_t        item;
    scope_item_t        hit;
    logic [COL_W-1:0]   column;
    logic [SEL_W-1:0]   trace;
    logic [LEVEL_W-1:0] level;
    int                 phase;
    int                 n;
    int                 roll;
    steps = '{8'd1, 8'd255, 8'd17, 8'd0, 8'd128, 8'd40};
    steps[4] = DATA_W'($urandom_range(2, 254));
    column_pool[0] = '0;
    column_pool[1] = '1;
    for (n = 2; n < 8; n++) column_pool[n] = COL_W'($urandom);
    for (phase = 0; phase < 6; phase++) begin
      write_step(steps[phase]);
      // no idle gaps in the middle phase, and none at all in the last part
      tx_idle_on = (phase != 2 && phase != 5);
      rx_idle_on = (phase != 2 && phase != 5);
      n = 0;
      while (n < 185) begin
        roll = $urandom_range(0, 99);
        if ((phase == 1 || phase == 3) && n == 90) begin
          item = bare_item(KIND_CLEAR);
          recent_q.delete();
        end else if (roll < 2) begin
          // ignored transaction, does not count
          send_item(bare_item(KIND_UNUSED));
          continue;
        end else if (roll < 55) begin
          column = ($urandom_range(0, 6) != 0) ? column_pool[$urandom_range(0, 7)]
                                               : COL_W'($urandom);
          item = pixel_item(column, pick_component(), pick_component(), pick_component());
          recent_q.push_back(item);
          if (recent_q.size() > 32) void'(recent_q.pop_front());
        end else if (recent_q.size() != 0 && $urandom_range(0, 4) != 0) begin
          hit = recent_q[$urandom_range(0, recent_q.size() - 1)];
          trace = SEL_W'($urandom);
          case (trace)
            TRACE_LUMA:  level = luma_of(hit.red, hit.green, hit.blue);
            TRACE_RED:   level = hit.red;
            TRACE_GREEN: level = hit.green;
            default:     level = hit.blue;
          endcase
          item = read_item(hit.column, trace, level);
        end else begin
          item = read_item(COL_W'($urandom), SEL_W'($urandom), LEVEL_W'($urandom));
        end
        send_item(item);
        n++;
      end
    end
  endtask

  initial begin : run_tests
    int tail_wait;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_step();
    test_extremes();
    test_clear();
    test_backpressure();
    test_random_traffic();
    // wind down: outstanding reads, then a wait for anything stray
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    tail_wait = 0;
    while (intensity_q.size() != 0 && tail_wait < 10000) begin
      @(negedge clk_i);
      tail_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (intensity_q.size() != 0) begin
      report_mismatch("reads left without a result", intensity_q.size(), 0);
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
